FILE: src/tipg_pkg.sv
// tipg_pkg: shared types and constants of the tape image pulse generator
// no dependencies; imported by the top level, tipg_front and tipg_back
package tipg_pkg;

	// configuration register indexes
	localparam logic [2:0] REG_IMAGE_LENGTH = 3'd0;
	localparam logic [2:0] REG_PILOT_COUNT  = 3'd1;
	localparam logic [2:0] REG_PILOT_TICKS  = 3'd2;
	localparam logic [2:0] REG_SYNC_HIGH    = 3'd3;
	localparam logic [2:0] REG_SYNC_LOW     = 3'd4;
	localparam logic [2:0] REG_ZERO_TICKS   = 3'd5;
	localparam logic [2:0] REG_ONE_TICKS    = 3'd6;

	// register reset values
	localparam logic [15:0] RST_PILOT_COUNT = 16'd5000;
	localparam logic [11:0] RST_PILOT_TICKS = 12'd2168;
	localparam logic [11:0] RST_SYNC_HIGH   = 12'd667;
	localparam logic [11:0] RST_SYNC_LOW    = 12'd735;
	localparam logic [11:0] RST_ZERO_TICKS  = 12'd855;
	localparam logic [11:0] RST_ONE_TICKS   = 12'd1710;

	// bits per image byte
	localparam logic [3:0] BITS_PER_BYTE = 4'd8;

	// command kinds passed from front to back
	typedef enum logic [1:0] {
		CMD_ERR,
		CMD_HEAD,
		CMD_DATA
	} cmd_kind_t;

	// one classified word from the front end
	typedef struct packed {
		cmd_kind_t   kind;
		logic [7:0]  data;
		logic        close;
		logic        done;
	} cmd_t;

	// register values the back end needs
	typedef struct packed {
		logic [15:0] pilot_count;
		logic [11:0] pilot_ticks;
		logic [11:0] sync_high;
		logic [11:0] sync_low;
		logic [11:0] zero_ticks;
		logic [11:0] one_ticks;
	} pulse_cfg_t;

	// one result word
	typedef struct packed {
		logic [11:0] high_len;
		logic [11:0] low_len;
		logic [15:0] repeat_res;
		logic        bad_length;
		logic        block_end;
		logic        image_done;
		logic        last;
	} result_t;

endpackage

FILE: src/tape_image_pulse_generator.sv
// tape_image_pulse_generator: top level with register file, front, back and queues
// depends on tipg_pkg, tipg_fifo, tipg_front and tipg_back
//
// Usage:
//  Input side is a queue: drive image_byte and raise push; a word is taken on
//  a rising edge with push high and full low. Bytes arrive in image file order.
//  Result side is a queue: while empty is low the oldest pulse word sits on
//  high_len, low_len, repeat_res, bad_length, block_end, image_done and last;
//  raising pop takes it. last marks the final word caused by one input byte.
//  Registers are written through cfg_we, cfg_index and cfg_data; the user must
//  write them only while the block is idle, which the block does not enforce; an
//  index past the register list is ignored. The back end emits one pulse word a
//  cycle while the result queue has room. A data byte gives a word per bit and a
//  block header a pilot and a sync word; either adds a block-end word when it
//  closes its block. The low length byte and bytes after a length error give no
//  word. A stalled receiver fills the result queue, then the command queue, after
//  which full rises; nothing is lost or repeated.
//  Reset clears both queues, the framing state and the byte count, and loads
//  the register defaults.
module tape_image_pulse_generator
	import tipg_pkg::*;
#(
	parameter int CMD_DEPTH = 4,
	parameter int RES_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  image_byte,
	output logic        empty,
	input  logic        pop,
	output logic [11:0] high_len,
	output logic [11:0] low_len,
	output logic [15:0] repeat_res,
	output logic        bad_length,
	output logic        block_end,
	output logic        image_done,
	output logic        last,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [23:0] cfg_data
);

	localparam logic [$clog2(CMD_DEPTH+1)-1:0] CMD_LIMIT = ($clog2(CMD_DEPTH+1))'(CMD_DEPTH - 1);

	logic [23:0] image_length_q;
	pulse_cfg_t  pcfg_q;

	logic        byte_valid;
	logic        cmd_push;
	cmd_t        cmd_in;
	cmd_t        cmd_out;
	logic        cmd_full;
	logic        cmd_full_raw;
	logic        cmd_empty;
	logic        cmd_pop;
	logic        res_push;
	logic        res_full;
	result_t     res_in;
	result_t     res_out;
	logic [$clog2(CMD_DEPTH+1)-1:0] cmd_used_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_length_q     <= '0;
			pcfg_q.pilot_count <= RST_PILOT_COUNT;
			pcfg_q.pilot_ticks <= RST_PILOT_TICKS;
			pcfg_q.sync_high   <= RST_SYNC_HIGH;
			pcfg_q.sync_low    <= RST_SYNC_LOW;
			pcfg_q.zero_ticks  <= RST_ZERO_TICKS;
			pcfg_q.one_ticks   <= RST_ONE_TICKS;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_IMAGE_LENGTH: image_length_q     <= cfg_data;
				REG_PILOT_COUNT:  pcfg_q.pilot_count <= cfg_data[15:0];
				REG_PILOT_TICKS:  pcfg_q.pilot_ticks <= cfg_data[11:0];
				REG_SYNC_HIGH:    pcfg_q.sync_high   <= cfg_data[11:0];
				REG_SYNC_LOW:     pcfg_q.sync_low    <= cfg_data[11:0];
				REG_ZERO_TICKS:   pcfg_q.zero_ticks  <= cfg_data[11:0];
				REG_ONE_TICKS:    pcfg_q.one_ticks   <= cfg_data[11:0];
				default: begin
				end
			endcase
		end
	end

	// input handshake: the word in the front register still needs a queue slot
	assign full       = cmd_full;
	assign byte_valid = push && !full;

	tipg_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_data    (image_byte),
		.image_length (image_length_q),
		.cmd_push     (cmd_push),
		.cmd          (cmd_in)
	);

	tipg_fifo #(
		.WIDTH ($bits(cmd_t)),
		.DEPTH (CMD_DEPTH)
	) u_cmd_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cmd_push),
		.wr_data (cmd_in),
		.full    (cmd_full_raw),
		.rd_en   (cmd_pop),
		.rd_data (cmd_out),
		.empty   (cmd_empty)
	);

	tipg_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_out),
		.cmd_valid (!cmd_empty),
		.cmd_pop   (cmd_pop),
		.pcfg      (pcfg_q),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res_in)
	);

	tipg_fifo #(
		.WIDTH ($bits(result_t)),
		.DEPTH (RES_DEPTH)
	) u_res_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_data (res_in),
		.full    (res_full),
		.rd_en   (pop),
		.rd_data (res_out),
		.empty   (empty)
	);

	// command queue occupancy, words landed minus words taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_used_q <= '0;
		end else begin
			unique case ({cmd_push, cmd_pop})
				2'b10:   cmd_used_q <= cmd_used_q + 1'b1;
				2'b01:   cmd_used_q <= cmd_used_q - 1'b1;
				default: cmd_used_q <= cmd_used_q;
			endcase
		end
	end

	// full once the word in flight would take the last free slot
	assign cmd_full = cmd_full_raw || (cmd_push && (cmd_used_q == CMD_LIMIT));

	assign high_len   = res_out.high_len;
	assign low_len    = res_out.low_len;
	assign repeat_res = res_out.repeat_res;
	assign bad_length = res_out.bad_length;
	assign block_end  = res_out.block_end;
	assign image_done = res_out.image_done;
	assign last       = res_out.last;

endmodule

FILE: src/tipg_fifo.sv
// tipg_fifo: small first-in first-out queue of packed words
// depends on nothing; used for the command queue and the result queue
module tipg_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == FULL_CNT);
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: src/tipg_front.sv
// tipg_front: takes image bytes, tracks block framing and checks block lengths
// depends on tipg_pkg; feeds classified words into the command queue
module tipg_front
	import tipg_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	input  logic [7:0]  byte_data,
	input  logic [23:0] image_length,
	output logic        cmd_push,
	output cmd_t        cmd
);

	typedef enum logic [1:0] {
		PH_LEN_LO,
		PH_LEN_HI,
		PH_DATA,
		PH_HALT
	} phase_t;

	phase_t      phase_q;
	logic [7:0]  length_low_q;
	logic [15:0] bytes_left_q;
	logic [23:0] bytes_taken_q;

	logic [23:0] taken_inc;
	logic [15:0] blk_len;
	logic [15:0] left_dec;
	logic        too_long;
	logic        done_now;

	// saturating byte count and length check
	always_comb begin
		taken_inc = (bytes_taken_q != '1) ? bytes_taken_q + 24'd1 : bytes_taken_q;
		blk_len   = {byte_data, length_low_q};
		left_dec  = bytes_left_q - 16'd1;
		too_long  = (taken_inc > image_length) ||
		            ({8'd0, blk_len} > (image_length - taken_inc));
		done_now  = (taken_inc >= image_length);
	end

	// framing state and command word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_LEN_LO;
			length_low_q  <= '0;
			bytes_left_q  <= '0;
			bytes_taken_q <= '0;
			cmd_push      <= 1'b0;
			cmd           <= '0;
		end else begin
			cmd_push <= 1'b0;
			if (byte_valid) begin
				unique case (phase_q)
					PH_LEN_LO: begin
						bytes_taken_q <= taken_inc;
						length_low_q  <= byte_data;
						phase_q       <= PH_LEN_HI;
					end
					PH_LEN_HI: begin
						bytes_taken_q <= taken_inc;
						cmd_push      <= 1'b1;
						cmd.data      <= byte_data;
						cmd.done      <= done_now;
						if (too_long) begin
							cmd.kind  <= CMD_ERR;
							cmd.close <= 1'b0;
							phase_q   <= PH_HALT;
						end else begin
							cmd.kind     <= CMD_HEAD;
							cmd.close    <= (blk_len == '0);
							bytes_left_q <= blk_len;
							phase_q      <= (blk_len == '0) ? PH_LEN_LO : PH_DATA;
						end
					end
					PH_DATA: begin
						bytes_taken_q <= taken_inc;
						bytes_left_q  <= left_dec;
						cmd_push      <= 1'b1;
						cmd.kind      <= CMD_DATA;
						cmd.data      <= byte_data;
						cmd.close     <= (left_dec == '0);
						cmd.done      <= done_now;
						phase_q       <= (left_dec == '0) ? PH_LEN_LO : PH_DATA;
					end
					PH_HALT: begin
						// halted after a bad length: bytes are swallowed
					end
					default: begin
					end
				endcase
			end
		end
	end

endmodule

FILE: src/tipg_back.sv
// tipg_back: expands each command into pulse words, one word a cycle while the result queue has room
// depends on tipg_pkg; reads the command queue, writes the result queue
module tipg_back
	import tipg_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cmd_t       cmd,
	input  logic       cmd_valid,
	output logic       cmd_pop,
	input  pulse_cfg_t pcfg,
	input  logic       res_full,
	output logic       res_push,
	output result_t    res
);

	logic [3:0] step_q;
	logic       final_word;
	logic [2:0] bit_idx;
	logic [11:0] bit_ticks;

	assign bit_idx   = 3'd7 - step_q[2:0];
	assign bit_ticks = cmd.data[bit_idx] ? pcfg.one_ticks : pcfg.zero_ticks;

	// pulse word for the current step of the current command
	always_comb begin
		res        = '0;
		final_word = 1'b0;
		unique case (cmd.kind)
			CMD_ERR: begin
				res.bad_length = 1'b1;
				res.last       = 1'b1;
				final_word     = 1'b1;
			end
			CMD_HEAD: begin
				if (step_q == 4'd0) begin
					res.high_len   = pcfg.pilot_ticks;
					res.low_len    = pcfg.pilot_ticks;
					res.repeat_res = pcfg.pilot_count;
				end else if (step_q == 4'd1) begin
					res.high_len   = pcfg.sync_high;
					res.low_len    = pcfg.sync_low;
					res.repeat_res = 16'd1;
					res.last       = !cmd.close;
					final_word     = !cmd.close;
				end else begin
					res.high_len   = pcfg.pilot_ticks;
					res.low_len    = pcfg.pilot_ticks;
					res.repeat_res = 16'd1;
					res.block_end  = 1'b1;
					res.image_done = cmd.done;
					res.last       = 1'b1;
					final_word     = 1'b1;
				end
			end
			CMD_DATA: begin
				if (step_q < BITS_PER_BYTE) begin
					res.high_len   = bit_ticks;
					res.low_len    = bit_ticks;
					res.repeat_res = 16'd1;
					res.last       = (step_q == BITS_PER_BYTE - 4'd1) && !cmd.close;
					final_word     = (step_q == BITS_PER_BYTE - 4'd1) && !cmd.close;
				end else begin
					res.high_len   = pcfg.pilot_ticks;
					res.low_len    = pcfg.pilot_ticks;
					res.repeat_res = 16'd1;
					res.block_end  = 1'b1;
					res.image_done = cmd.done;
					res.last       = 1'b1;
					final_word     = 1'b1;
				end
			end
			default: begin
				final_word = 1'b1;
			end
		endcase
	end

	assign res_push = cmd_valid && !res_full;
	assign cmd_pop  = cmd_valid && !res_full && final_word;

	// step within the current command
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (cmd_valid && !res_full) begin
			step_q <= final_word ? 4'd0 : step_q + 4'd1;
		end
	end

endmodule
